>>> rtl/ffsa_pkg.sv
// Shared types and constants for the first-fit slot allocator.
// No dependencies; used by first_fit_slot_allocator.
package ffsa_pkg;

    localparam int SLOTS    = 256;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int POS_W    = (IDX_W + 2 > 10) ? IDX_W + 2 : 10;
    localparam int COUNT_W  = 8;
    localparam int OFFSET_W = 8;
    localparam int PEAK_W   = 9;
    localparam int LEN_W    = 2;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam pos_t   OFFSET_MAX = pos_t'(255);
    localparam pos_t   PEAK_MAX   = pos_t'(511);
    localparam pos_t   SLOT_LIMIT = pos_t'(SLOTS);
    localparam idx_t   LAST_SLOT  = idx_t'(SLOTS - 1);
    localparam count_t COUNT_MAX  = count_t'(255);
    localparam count_t COUNT_ONE  = count_t'(1);

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_SHARE   = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

endpackage

>>> rtl/ffsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-slot use counts of the allocator.
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/first_fit_slot_allocator.sv
// First-fit slot allocator: per-slot use counts, run allocate/release/share/clear.
// Depends on ffsa_pkg and ffsa_ram.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------
//  in      | in_valid  | in_stall  | command, run_length, slot_offset
//  out     | out_valid | out_stall | alloc_offset, status, peak_use
//
// One item at a time. Allocate scans the count RAM one slot per clock from
// slot 0, then writes a count of one to each slot of the run. Release and
// share read, then write, each slot of the run, skip each slot past the
// stack, and then close; clear and a zero-length allocate finish in the
// accept clock. After reset every count reads zero at once (per-slot valid
// bits); no clearing pass.
// in_stall is high while an item is in work or its result is not yet taken.
module first_fit_slot_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [ffsa_pkg::LEN_W-1:0]    run_length,
    input  logic [ffsa_pkg::OFFSET_W-1:0] slot_offset,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ffsa_pkg::OFFSET_W-1:0] alloc_offset,
    output logic                          status,
    output logic [ffsa_pkg::PEAK_W-1:0]   peak_use
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC_WR,
        S_ADJ_RD,
        S_ADJ_WR
    } state_t;

    state_t                          state_reg;
    ffsa_pkg::cmd_t                  cmd_reg;
    logic [ffsa_pkg::LEN_W-1:0]      len_reg;
    logic [ffsa_pkg::OFFSET_W-1:0]   offset_reg;
    logic [ffsa_pkg::SLOTS-1:0]      slot_valid_reg;
    logic [ffsa_pkg::PEAK_W-1:0]     peak_reg;

    ffsa_pkg::idx_t                  scan_idx_reg;
    ffsa_pkg::idx_t                  chk_idx_reg;
    logic                            chk_valid_reg;
    logic [ffsa_pkg::LEN_W-1:0]      run_reg;

    ffsa_pkg::pos_t                  start_reg;
    ffsa_pkg::pos_t                  wr_ptr_reg;
    logic [ffsa_pkg::LEN_W-1:0]      wr_left_reg;

    logic [ffsa_pkg::LEN_W-1:0]      adj_k_reg;
    ffsa_pkg::idx_t                  adj_idx_reg;

    logic                            out_valid_reg;
    logic [ffsa_pkg::OFFSET_W-1:0]   alloc_offset_reg;
    logic                            status_reg;

    logic                            accept;
    ffsa_pkg::cmd_t                  in_cmd;

    ffsa_pkg::idx_t                  ram_raddr;
    ffsa_pkg::idx_t                  ram_waddr;
    ffsa_pkg::count_t                ram_wdata;
    ffsa_pkg::count_t                ram_rdata;
    logic                            ram_we;

    logic                            chk_free;
    logic [ffsa_pkg::LEN_W-1:0]      run_inc;
    ffsa_pkg::pos_t                  found_start;
    ffsa_pkg::pos_t                  alloc_end;
    logic [ffsa_pkg::PEAK_W-1:0]     alloc_end_sat;
    ffsa_pkg::pos_t                  adj_pos;
    ffsa_pkg::count_t                adj_cur;
    ffsa_pkg::count_t                adj_new;

    assign in_stall     = (state_reg != S_IDLE) || out_valid_reg;
    assign accept       = in_valid && !in_stall;
    assign in_cmd       = ffsa_pkg::cmd_t'(command);
    assign out_valid    = out_valid_reg;
    assign alloc_offset = alloc_offset_reg;
    assign status       = status_reg;
    assign peak_use     = peak_reg;

    // Scan datapath: the slot read last cycle is checked now
    assign chk_free    = !slot_valid_reg[chk_idx_reg] || (ram_rdata == '0);
    assign run_inc     = run_reg + 1'b1;
    assign found_start = ffsa_pkg::pos_t'(chk_idx_reg) + ffsa_pkg::pos_t'(1)
                       - ffsa_pkg::pos_t'(len_reg);

    // Run end after the last write of an allocation
    assign alloc_end     = wr_ptr_reg + ffsa_pkg::pos_t'(1);
    assign alloc_end_sat = (alloc_end > ffsa_pkg::PEAK_MAX)
                         ? ffsa_pkg::PEAK_W'(ffsa_pkg::PEAK_MAX)
                         : alloc_end[ffsa_pkg::PEAK_W-1:0];

    // Release/share datapath
    assign adj_pos = ffsa_pkg::pos_t'(offset_reg) + ffsa_pkg::pos_t'(adj_k_reg);
    assign adj_cur = slot_valid_reg[adj_idx_reg] ? ram_rdata : '0;

    always_comb
    begin
        adj_new = adj_cur;
        if (cmd_reg == ffsa_pkg::CMD_SHARE)
        begin
            if (adj_cur != ffsa_pkg::COUNT_MAX)
            begin
                adj_new = adj_cur + 1'b1;
            end
        end
        else if (adj_cur != '0)
        begin
            adj_new = adj_cur - 1'b1;
        end
    end

    always_comb
    begin
        ram_raddr = (state_reg == S_SCAN) ? scan_idx_reg
                                          : adj_pos[ffsa_pkg::IDX_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = adj_idx_reg;
        ram_wdata = adj_new;
        unique case (state_reg)
            S_ALLOC_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_ptr_reg[ffsa_pkg::IDX_W-1:0];
                ram_wdata = ffsa_pkg::COUNT_ONE;
            end
            S_ADJ_WR:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    ffsa_ram #(
        .WIDTH (ffsa_pkg::COUNT_W),
        .DEPTH (ffsa_pkg::SLOTS)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cmd_reg          <= ffsa_pkg::CMD_ALLOC;
            len_reg          <= '0;
            offset_reg       <= '0;
            slot_valid_reg   <= '0;
            peak_reg         <= '0;
            scan_idx_reg     <= '0;
            chk_idx_reg      <= '0;
            chk_valid_reg    <= 1'b0;
            run_reg          <= '0;
            start_reg        <= '0;
            wr_ptr_reg       <= '0;
            wr_left_reg      <= '0;
            adj_k_reg        <= '0;
            adj_idx_reg      <= '0;
            out_valid_reg    <= 1'b0;
            alloc_offset_reg <= '0;
            status_reg       <= ffsa_pkg::ST_OK;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg       <= in_cmd;
                        len_reg       <= run_length;
                        offset_reg    <= slot_offset;
                        scan_idx_reg  <= '0;
                        chk_valid_reg <= 1'b0;
                        run_reg       <= '0;
                        adj_k_reg     <= '0;
                        unique case (in_cmd)
                            ffsa_pkg::CMD_ALLOC:
                            begin
                                if (run_length == '0)
                                begin
                                    out_valid_reg    <= 1'b1;
                                    alloc_offset_reg <= '0;
                                    status_reg       <= ffsa_pkg::ST_FULL;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            ffsa_pkg::CMD_RELEASE,
                            ffsa_pkg::CMD_SHARE:
                            begin
                                state_reg <= S_ADJ_RD;
                            end
                            ffsa_pkg::CMD_CLEAR:
                            begin
                                slot_valid_reg   <= '0;
                                peak_reg         <= '0;
                                out_valid_reg    <= 1'b1;
                                alloc_offset_reg <= '0;
                                status_reg       <= ffsa_pkg::ST_OK;
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    // advance the read side, holding at the last slot
                    if (scan_idx_reg != ffsa_pkg::LAST_SLOT)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    chk_idx_reg   <= scan_idx_reg;
                    chk_valid_reg <= 1'b1;
                    if (chk_valid_reg)
                    begin
                        run_reg <= chk_free ? run_inc : '0;
                        if (chk_free && (run_inc == len_reg))
                        begin
                            if (found_start > ffsa_pkg::OFFSET_MAX)
                            begin
                                state_reg        <= S_IDLE;
                                out_valid_reg    <= 1'b1;
                                alloc_offset_reg <= '0;
                                status_reg       <= ffsa_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_reg   <= S_ALLOC_WR;
                                start_reg   <= found_start;
                                wr_ptr_reg  <= found_start;
                                wr_left_reg <= len_reg;
                            end
                        end
                        else if (chk_idx_reg == ffsa_pkg::LAST_SLOT)
                        begin
                            state_reg        <= S_IDLE;
                            out_valid_reg    <= 1'b1;
                            alloc_offset_reg <= '0;
                            status_reg       <= ffsa_pkg::ST_FULL;
                        end
                    end
                end

                S_ALLOC_WR:
                begin
                    slot_valid_reg[wr_ptr_reg[ffsa_pkg::IDX_W-1:0]] <= 1'b1;
                    wr_ptr_reg  <= wr_ptr_reg + 1'b1;
                    wr_left_reg <= wr_left_reg - 1'b1;
                    if (wr_left_reg == ffsa_pkg::LEN_W'(1))
                    begin
                        if (alloc_end_sat > peak_reg)
                        begin
                            peak_reg <= alloc_end_sat;
                        end
                        state_reg        <= S_IDLE;
                        out_valid_reg    <= 1'b1;
                        alloc_offset_reg <= start_reg[ffsa_pkg::OFFSET_W-1:0];
                        status_reg       <= ffsa_pkg::ST_OK;
                    end
                end

                S_ADJ_RD:
                begin
                    if (adj_k_reg == len_reg)
                    begin
                        state_reg        <= S_IDLE;
                        out_valid_reg    <= 1'b1;
                        alloc_offset_reg <= '0;
                        status_reg       <= ffsa_pkg::ST_OK;
                    end
                    else if (adj_pos >= ffsa_pkg::SLOT_LIMIT)
                    begin
                        // drop slots past the stack
                        adj_k_reg <= adj_k_reg + 1'b1;
                    end
                    else
                    begin
                        adj_idx_reg <= adj_pos[ffsa_pkg::IDX_W-1:0];
                        state_reg   <= S_ADJ_WR;
                    end
                end

                S_ADJ_WR:
                begin
                    slot_valid_reg[adj_idx_reg] <= 1'b1;
                    adj_k_reg <= adj_k_reg + 1'b1;
                    state_reg <= S_ADJ_RD;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
